FILE: design/tdl_pkg.sv
// ----------------------------------------------------------------------------
// tdl_pkg
// Shared types and constants of the three-phase duty limiter.
// ----------------------------------------------------------------------------
package tdl_pkg;

    localparam int TDL_DIV_STAGES = 8;
    localparam int TDL_PHASE_LAT  = TDL_DIV_STAGES + 3;
    localparam int TDL_LAT        = 3 * TDL_PHASE_LAT + 1;

    typedef enum logic {
        CFG_MID_COUNT     = 1'b0,
        CFG_MAX_MAGNITUDE = 1'b1
    } t_cfg_idx;

    // Side data that travels with one phase check through the divider.
    typedef struct packed {
        logic               hit;
        logic               neg;
        logic               sy;
        logic               sz;
        logic [14:0]        lim;
        logic [15:0]        mag;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_side;

endpackage

FILE: design/tdl_div_stage.sv
// ----------------------------------------------------------------------------
// tdl_div_stage
// One registered stage of a restoring divider, two quotient bits per stage.
// ----------------------------------------------------------------------------
module tdl_div_stage (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_rem,
    input  logic [15:0] i_q,
    input  logic [15:0] i_mag,
    output logic [15:0] o_rem,
    output logic [15:0] o_q
);
    logic [15:0] r_rem, n_rem;
    logic [15:0] r_q, n_q;
    logic [16:0] t0, t1;
    logic [15:0] rem1;
    logic [15:0] q1;

    always_comb begin
        t0 = {i_rem, i_q[15]};
        if (t0 >= {1'b0, i_mag}) begin
            rem1 = 16'(t0 - {1'b0, i_mag});
            q1   = {i_q[14:0], 1'b1};
        end else begin
            rem1 = t0[15:0];
            q1   = {i_q[14:0], 1'b0};
        end
        t1 = {rem1, q1[15]};
        if (t1 >= {1'b0, i_mag}) begin
            n_rem = 16'(t1 - {1'b0, i_mag});
            n_q   = {q1[14:0], 1'b1};
        end else begin
            n_rem = t1[15:0];
            n_q   = {q1[14:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_rem = r_rem;
    assign o_q   = r_q;
endmodule

FILE: design/tdl_phase.sv
// ----------------------------------------------------------------------------
// tdl_phase
// Pipelined check of one phase: if it exceeds the limit, clamps it and scales the other two.
// ----------------------------------------------------------------------------
module tdl_phase (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [14:0]        i_lim,
    input  logic signed [15:0] i_x,
    input  logic signed [15:0] i_y,
    input  logic signed [15:0] i_z,
    output logic signed [15:0] o_x,
    output logic signed [15:0] o_y,
    output logic signed [15:0] o_z
);
    import tdl_pkg::*;

    t_side              r_s0, n_s0;
    logic signed [31:0] r_py, r_pz, n_py, n_pz;
    t_side              r_s1, n_s1;
    logic [29:0]        ay, az;
    logic [15:0]        rem_y [TDL_DIV_STAGES+1];
    logic [15:0]        q_y   [TDL_DIV_STAGES+1];
    logic [15:0]        rem_z [TDL_DIV_STAGES+1];
    logic [15:0]        q_z   [TDL_DIV_STAGES+1];
    logic [15:0]        r_rem_y, r_q_y, r_rem_z, r_q_z;
    t_side              r_sd [TDL_DIV_STAGES];
    t_side              sd   [TDL_DIV_STAGES+1];
    logic signed [15:0] r_x, r_y, r_z, n_x, n_y, n_z;
    logic [16:0]        mag_x;
    t_side              sl;

    always_comb begin
        mag_x      = i_x[15] ? 17'(-{i_x[15], i_x}) : {1'b0, i_x};
        n_s0       = '0;
        n_s0.hit   = mag_x > {2'b00, i_lim};
        n_s0.neg   = i_x[15];
        n_s0.lim   = i_lim;
        n_s0.mag   = mag_x[15:0];
        n_s0.x     = i_x;
        n_s0.y     = i_y;
        n_s0.z     = i_z;
        n_py       = 32'(i_y * $signed({1'b0, i_lim}));
        n_pz       = 32'(i_z * $signed({1'b0, i_lim}));
        n_s1       = r_s0;
        n_s1.sy    = r_py[31];
        n_s1.sz    = r_pz[31];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0    <= n_s0;
            r_py    <= n_py;
            r_pz    <= n_pz;
            r_s1    <= n_s1;
            r_rem_y <= {2'b00, ay[29:16]};
            r_q_y   <= ay[15:0];
            r_rem_z <= {2'b00, az[29:16]};
            r_q_z   <= az[15:0];
        end
    end

    assign ay = r_py[31] ? 30'(-r_py) : r_py[29:0];
    assign az = r_pz[31] ? 30'(-r_pz) : r_pz[29:0];

    assign rem_y[0] = r_rem_y;
    assign q_y[0]   = r_q_y;
    assign rem_z[0] = r_rem_z;
    assign q_z[0]   = r_q_z;
    assign sd[0]    = r_s1;

    for (genvar g = 0; g < TDL_DIV_STAGES; g++) begin : g_div
        tdl_div_stage u_dy (
            .i_clk (i_clk), .i_en (i_en), .i_rem (rem_y[g]), .i_q (q_y[g]),
            .i_mag (sd[g].mag),
            .o_rem (rem_y[g+1]), .o_q (q_y[g+1])
        );
        tdl_div_stage u_dz (
            .i_clk (i_clk), .i_en (i_en), .i_rem (rem_z[g]), .i_q (q_z[g]),
            .i_mag (sd[g].mag),
            .o_rem (rem_z[g+1]), .o_q (q_z[g+1])
        );
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sd[g] <= sd[g];
            end
        end
        assign sd[g+1] = r_sd[g];
    end

    always_comb begin
        sl = sd[TDL_DIV_STAGES];
        if (sl.hit) begin
            n_x = sl.neg ? -$signed({1'b0, sl.lim}) : $signed({1'b0, sl.lim});
            n_y = sl.sy ? 16'(-q_y[TDL_DIV_STAGES]) : q_y[TDL_DIV_STAGES];
            n_z = sl.sz ? 16'(-q_z[TDL_DIV_STAGES]) : q_z[TDL_DIV_STAGES];
        end else begin
            n_x = sl.x;
            n_y = sl.y;
            n_z = sl.z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

FILE: design/three_phase_duty_limiter_top.sv
// ----------------------------------------------------------------------------
// three_phase_duty_limiter_top
// Limits three phase voltage commands and turns them into duty compare values.
// ----------------------------------------------------------------------------
// A request on the input channel carries three signed phase commands; a
// request on the output channel carries the three duty compare values.
// The two registers are written through the plain write port; the user must
// do so only while the block is idle, which the block does not enforce.
// Index 0 is the midpoint count, index 1 the limit. Each request passes three
// phase checks of eleven stages each (a multiply, setup, an eight-stage
// divider at two quotient bits per stage, and the select), then the output
// adder. One request is taken every cycle while the output side takes results.
// The whole pipeline advances on one enable; when the receiver stalls with
// a result waiting, the pipeline and the input hold until it is taken.
// Reset clears the valid bits and both registers.
// ----------------------------------------------------------------------------
module three_phase_duty_limiter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [14:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_phase_a_cmd,
    input  logic [15:0] i_phase_b_cmd,
    input  logic [15:0] i_phase_c_cmd,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_duty_a,
    output logic [15:0] o_duty_b,
    output logic [15:0] o_duty_c
);
    import tdl_pkg::*;

    logic [14:0]        r_mid, r_lim;
    logic [TDL_LAT-1:0] r_vld;
    logic               en;
    logic signed [15:0] a1, b1, c1, b2, a2, c2, c3, a3, b3;
    logic [15:0]        r_da, r_db, r_dc;

    assign en         = !r_vld[TDL_LAT-1] || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid <= '0;
            r_lim <= '0;
            r_vld <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_MID_COUNT:     r_mid <= i_cfg_data;
                    CFG_MAX_MAGNITUDE: r_lim <= i_cfg_data;
                    default:           r_mid <= r_mid;
                endcase
            end
            if (en) begin
                r_vld <= {r_vld[TDL_LAT-2:0], i_in_valid};
            end
        end
    end

    tdl_phase u_pa (
        .i_clk (i_clk), .i_en (en), .i_lim (r_lim),
        .i_x (i_phase_a_cmd), .i_y (i_phase_b_cmd), .i_z (i_phase_c_cmd),
        .o_x (a1), .o_y (b1), .o_z (c1)
    );
    tdl_phase u_pb (
        .i_clk (i_clk), .i_en (en), .i_lim (r_lim),
        .i_x (b1), .i_y (a1), .i_z (c1),
        .o_x (b2), .o_y (a2), .o_z (c2)
    );
    tdl_phase u_pc (
        .i_clk (i_clk), .i_en (en), .i_lim (r_lim),
        .i_x (c2), .i_y (a2), .i_z (b2),
        .o_x (c3), .o_y (a3), .o_z (b3)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_da <= 16'({1'b0, r_mid} + a3);
            r_db <= 16'({1'b0, r_mid} + b3);
            r_dc <= 16'({1'b0, r_mid} + c3);
        end
    end

    assign o_out_valid = r_vld[TDL_LAT-1];
    assign o_duty_a    = r_da;
    assign o_duty_b    = r_db;
    assign o_duty_c    = r_dc;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result valid right after reset.");

    a_ready_when_empty: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) !o_out_valid |-> o_in_ready)
        else $error("Input blocked with no result waiting.");

    a_stall_holds: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) (o_out_valid && !i_out_ready) |=> $stable(r_vld))
        else $error("Pipeline moved during an output stall.");
`endif
endmodule
